/* rtl/ubx_pkg.sv */
// Shared types, codes and tables for the UBX frame parser.
// Used by ubx_parse, ubx_emit and ubx_frame_parser; depends on nothing.
package ubx_pkg;

  localparam logic [7:0]  SYNC_1       = 8'hB5;
  localparam logic [7:0]  SYNC_2       = 8'h62;
  localparam logic [7:0]  CLASS_NAV    = 8'h01;
  localparam logic [7:0]  ID_NAV_PVT   = 8'h07;
  localparam logic [7:0]  CLASS_ACK    = 8'h05;
  localparam logic [7:0]  ID_ACK_ACK   = 8'h01;
  localparam logic [7:0]  ID_ACK_NAK   = 8'h00;
  localparam logic [15:0] ACK_LEN      = 16'd2;
  localparam logic [15:0] PVT_MIN_LEN  = 16'd92;
  localparam logic [3:0]  PVT_LAST_TAG = 4'd13;
  localparam logic [3:0]  ACK_LAST_TAG = 4'd0;

  typedef enum logic [3:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LENLO,
    PH_LENHI,
    PH_PAYLOAD,
    PH_CKA,
    PH_CKB
  } phase_t;

  typedef enum logic [1:0] {
    KIND_ACK = 2'd0,
    KIND_NAK = 2'd1,
    KIND_PVT = 2'd2
  } kind_t;

  typedef struct packed {
    logic       start;
    kind_t      kind;
    logic [3:0] last_tag;
  } emit_req_t;

  // Word address (byte offset / 4) of each position word in the payload store.
  function automatic logic [4:0] pvt_word(input logic [3:0] tag);
    logic [4:0] w;
    case (tag)
      4'd0:    w = 5'd1;
      4'd1:    w = 5'd2;
      4'd2:    w = 5'd5;
      4'd3:    w = 5'd6;
      4'd4:    w = 5'd7;
      4'd5:    w = 5'd9;
      4'd6:    w = 5'd10;
      4'd7:    w = 5'd11;
      4'd8:    w = 5'd12;
      4'd9:    w = 5'd13;
      4'd10:   w = 5'd14;
      4'd11:   w = 5'd15;
      4'd12:   w = 5'd16;
      4'd13:   w = 5'd17;
      default: w = 5'd0;
    endcase
    return w;
  endfunction

endpackage

/* rtl/ubx_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the payload word store.
module ubx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 18
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/ubx_parse.sv */
// Byte-level frame parser: sync hunt, header, Fletcher sums, payload packing.
// Depends on ubx_pkg; writes packed payload words into the store RAM.
module ubx_parse #(
  parameter int CAPTURE_BYTES = 72,
  parameter int ADDR_W        = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  input  logic                 emit_busy,
  output logic                 wr_en,
  output logic [ADDR_W-1:0]    wr_addr,
  output logic [31:0]          wr_data,
  output ubx_pkg::emit_req_t   req
);
  import ubx_pkg::*;

  localparam logic [15:0] CAP = 16'(CAPTURE_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  ck_a_r, ck_a_nxt;
  logic [23:0] word_r, word_nxt;
  logic        accept;
  logic [7:0]  b;
  logic [7:0]  add_a;
  logic [15:0] idx_inc;
  logic        sums_ok;
  logic        is_ack;
  logic        is_pvt;

  assign b        = in_rx_byte;
  assign in_stall = emit_busy && (phase_r == PH_PAYLOAD || phase_r == PH_CKB);
  assign accept   = in_valid && !in_stall;
  assign add_a    = sum_a_r + b;
  assign idx_inc  = idx_r + 16'd1;
  assign sums_ok  = (ck_a_r == sum_a_r) && (b == sum_b_r);
  assign is_ack   = (class_r == CLASS_ACK) && (id_r == ID_ACK_ACK || id_r == ID_ACK_NAK)
                    && (len_r == ACK_LEN);
  assign is_pvt   = (class_r == CLASS_NAV) && (id_r == ID_NAV_PVT) && (len_r >= PVT_MIN_LEN);

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      case (phase_r)
        PH_SYNC1:   if (b == SYNC_1) phase_nxt = PH_SYNC2;
        PH_SYNC2: begin
          if (b == SYNC_2) begin
            phase_nxt = PH_CLASS;
          end else if (b != SYNC_1) begin
            phase_nxt = PH_SYNC1;
          end
        end
        PH_CLASS:   phase_nxt = PH_ID;
        PH_ID:      phase_nxt = PH_LENLO;
        PH_LENLO:   phase_nxt = PH_LENHI;
        PH_LENHI:   phase_nxt = ({b, len_r[7:0]} == 16'd0) ? PH_CKA : PH_PAYLOAD;
        PH_PAYLOAD: if (idx_inc >= len_r) phase_nxt = PH_CKA;
        PH_CKA:     phase_nxt = PH_CKB;
        PH_CKB:     phase_nxt = PH_SYNC1;
        default:    phase_nxt = PH_SYNC1;
      endcase
    end
  end

  always_comb begin
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    class_nxt = class_r;
    id_nxt    = id_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    ck_a_nxt  = ck_a_r;
    word_nxt  = word_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r[ADDR_W+1:2];
    wr_data   = '0;
    req       = '0;
    case (idx_r[1:0])
      2'd0:    wr_data = {24'd0, b};
      2'd1:    wr_data = {16'd0, b, word_r[7:0]};
      2'd2:    wr_data = {8'd0, b, word_r[15:0]};
      default: wr_data = {b, word_r};
    endcase
    if (accept) begin
      case (phase_r)
        PH_SYNC2: begin
          if (b == SYNC_2) begin
            sum_a_nxt = '0;
            sum_b_nxt = '0;
          end
        end
        PH_CLASS, PH_ID, PH_LENLO, PH_LENHI: begin
          sum_a_nxt = add_a;
          sum_b_nxt = sum_b_r + add_a;
          if (phase_r == PH_CLASS) class_nxt = b;
          if (phase_r == PH_ID) id_nxt = b;
          if (phase_r == PH_LENLO) len_nxt = {8'd0, b};
          if (phase_r == PH_LENHI) begin
            len_nxt = {b, len_r[7:0]};
            idx_nxt = '0;
          end
        end
        PH_PAYLOAD: begin
          sum_a_nxt = add_a;
          sum_b_nxt = sum_b_r + add_a;
          idx_nxt   = idx_inc;
          case (idx_r[1:0])
            2'd0:    word_nxt[7:0]   = b;
            2'd1:    word_nxt[15:8]  = b;
            2'd2:    word_nxt[23:16] = b;
            default: word_nxt        = word_r;
          endcase
          wr_en = (idx_r < CAP) &&
                  (idx_r[1:0] == 2'd3 || idx_inc >= len_r || idx_inc == CAP);
        end
        PH_CKA: ck_a_nxt = b;
        PH_CKB: begin
          if (sums_ok && is_ack) begin
            req.start    = 1'b1;
            req.kind     = (id_r == ID_ACK_NAK) ? KIND_NAK : KIND_ACK;
            req.last_tag = ACK_LAST_TAG;
          end else if (sums_ok && is_pvt) begin
            req.start    = 1'b1;
            req.kind     = KIND_PVT;
            req.last_tag = PVT_LAST_TAG;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      len_r   <= '0;
      idx_r   <= '0;
      class_r <= '0;
      id_r    <= '0;
      sum_a_r <= '0;
      sum_b_r <= '0;
      ck_a_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      class_r <= class_nxt;
      id_r    <= id_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      ck_a_r  <= ck_a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !emit_busy)
    else $error("payload store written while a frame is being emitted");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (idx_r < CAP) && (phase_r == PH_PAYLOAD))
    else $error("payload store write outside the capture window");

endmodule

/* rtl/ubx_emit.sv */
// Result emitter: reads payload words from the store and sends result items.
// Depends on ubx_pkg; the RAM output register acts as a skid stage.
module ubx_emit #(
  parameter int ADDR_W = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ubx_pkg::emit_req_t req,
  output logic               busy,
  output logic               rd_en,
  output logic [ADDR_W-1:0]  rd_addr,
  input  logic [31:0]        rd_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [3:0]         out_tag,
  output logic [31:0]        out_value,
  output logic               out_last
);
  import ubx_pkg::*;

  logic        busy_r, busy_nxt;
  kind_t       kind_r, kind_nxt;
  logic [3:0]  last_tag_r, last_tag_nxt;
  logic [3:0]  iss_r, iss_nxt;
  logic        iss_done_r, iss_done_nxt;
  logic        dv_r, dv_nxt;
  logic [3:0]  dtag_r, dtag_nxt;
  logic        ov_r, ov_nxt;
  logic [3:0]  otag_r, otag_nxt;
  logic [31:0] oval_r, oval_nxt;
  logic        olast_r, olast_nxt;
  logic        load;
  logic        out_xfer;

  assign out_xfer = ov_r && !out_stall;
  assign load     = dv_r && (!ov_r || !out_stall);
  assign rd_en    = busy_r && !iss_done_r && (!dv_r || load);
  assign rd_addr  = (kind_r == KIND_PVT) ? ADDR_W'(pvt_word(iss_r)) : '0;
  assign busy     = busy_r;

  assign out_valid = ov_r;
  assign out_kind  = kind_r;
  assign out_tag   = otag_r;
  assign out_value = oval_r;
  assign out_last  = olast_r;

  always_comb begin
    busy_nxt     = busy_r;
    kind_nxt     = kind_r;
    last_tag_nxt = last_tag_r;
    iss_nxt      = iss_r;
    iss_done_nxt = iss_done_r;
    dv_nxt       = dv_r;
    dtag_nxt     = dtag_r;
    ov_nxt       = ov_r;
    otag_nxt     = otag_r;
    oval_nxt     = oval_r;
    olast_nxt    = olast_r;
    if (out_xfer) begin
      ov_nxt = 1'b0;
      if (olast_r) busy_nxt = 1'b0;
    end
    if (load) begin
      ov_nxt    = 1'b1;
      dv_nxt    = 1'b0;
      otag_nxt  = dtag_r;
      olast_nxt = (dtag_r == last_tag_r);
      oval_nxt  = (kind_r == KIND_PVT) ? rd_data : {16'd0, rd_data[15:0]};
    end
    if (rd_en) begin
      dv_nxt   = 1'b1;
      dtag_nxt = iss_r;
      iss_nxt  = iss_r + 4'd1;
      if (iss_r == last_tag_r) iss_done_nxt = 1'b1;
    end
    if (req.start) begin
      busy_nxt     = 1'b1;
      kind_nxt     = req.kind;
      last_tag_nxt = req.last_tag;
      iss_nxt      = '0;
      iss_done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      kind_r     <= KIND_ACK;
      last_tag_r <= '0;
      iss_r      <= '0;
      iss_done_r <= 1'b1;
      dv_r       <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      kind_r     <= kind_nxt;
      last_tag_r <= last_tag_nxt;
      iss_r      <= iss_nxt;
      iss_done_r <= iss_done_nxt;
      dv_r       <= dv_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dtag_r  <= dtag_nxt;
    otag_r  <= otag_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
  end

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("new frame started while the previous one is still emitting");

  a_pending_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r || ov_r) |-> busy_r)
    else $error("result data held while the emitter is idle");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && olast_r && !out_stall) |=> !ov_r && !dv_r)
    else $error("result word follows the last word of a frame");

  a_ack_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && kind_r != KIND_PVT) |-> olast_r && (otag_r == 4'd0))
    else $error("acknowledge result is not a single last word");

endmodule

/* rtl/ubx_frame_parser.sv */
// Top level of the UBX frame parser: parser, payload word store and emitter.
// Depends on ubx_pkg, ubx_parse, ubx_ram and ubx_emit.
//
//   channel  | ports                                        | direction
//   ---------+----------------------------------------------+----------
//   input    | in_valid, in_stall, in_rx_byte               | in
//   result   | out_valid, out_stall, out_kind, out_tag,     | out
//            | out_value, out_last                          |
//
// One byte is taken per cycle while a frame is parsed and the input is not held off.
// A valid frame starts emission after its last checksum byte; results leave at one word
// per cycle from the store's read port unless stalled, one word for an acknowledge and
// fourteen for a position frame. During emission the input is held off only at payload
// and final checksum bytes of the next frame, so no unread word is overwritten early.
// Reset is synchronous and clears control state only; the store needs no clearing.
module ubx_frame_parser #(
  parameter int CAPTURE_BYTES = 72
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_tag,
  output logic [31:0] out_value,
  output logic        out_last
);
  import ubx_pkg::*;

  localparam int WORDS  = (CAPTURE_BYTES + 3) / 4;
  localparam int ADDR_W = $clog2(WORDS);

  emit_req_t         req;
  logic              emit_busy;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       rd_data;

  ubx_parse #(
    .CAPTURE_BYTES(CAPTURE_BYTES),
    .ADDR_W       (ADDR_W)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_rx_byte(in_rx_byte),
    .emit_busy (emit_busy),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .req       (req)
  );

  ubx_ram #(
    .WIDTH(32),
    .DEPTH(WORDS)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  ubx_emit #(
    .ADDR_W(ADDR_W)
  ) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .busy     (emit_busy),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind (out_kind),
    .out_tag  (out_tag),
    .out_value(out_value),
    .out_last (out_last)
  );

endmodule

/* sim/ubx_frame_parser_test.sv */
// Self-checking testbench for ubx_frame_parser: streams sync, header, payload and checksum
// bytes and checks every result word against a byte-level parser model kept alongside.
// Depends on ubx_pkg and the ubx_frame_parser RTL.
module ubx_frame_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ubx_pkg::*;

  localparam int CAPTURE = 72;
  localparam int PVT_WORD_COUNT = 14;

  typedef logic [7:0] byte_q_t [$];

  typedef struct {
    kind_t       kind;
    logic [3:0]  tag;
    logic [31:0] value;
    logic        last;
  } result_word_t;

  typedef enum int {
    CK_GOOD,
    CK_BAD_A,
    CK_BAD_B
  } check_fault_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [3:0]  out_tag;
  logic [31:0] out_value;
  logic        out_last;

  phase_t      rx_phase = PH_SYNC1;
  logic [15:0] rx_len = 16'h0000;
  logic [15:0] rx_index = 16'h0000;
  logic [7:0]  rx_class = 8'h00;
  logic [7:0]  rx_id = 8'h00;
  logic [7:0]  run_a = 8'h00;
  logic [7:0]  run_b = 8'h00;
  logic [7:0]  rx_ck_a = 8'h00;
  logic [7:0]  rx_payload [CAPTURE];

  result_word_t expected_words [$];

  int  fail_count = 0;
  int  bytes_sent = 0;
  int  frames_sent = 0;
  int  words_checked = 0;
  bit  in_steady = 1'b0;
  bit  out_steady = 1'b0;
  int  stall_left = 5;
  int  stall_mark = 0;

  ubx_frame_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_tag    (out_tag),
    .out_value  (out_value),
    .out_last   (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #10ms;
    $display("FAIL");
    $finish;
  end

  function automatic int draw_wait(inout bit steady);
    if ($urandom_range(0, 29) == 0) steady = !steady;
    return steady ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic byte_q_t random_body(input int n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom));
    return q;
  endfunction

  function automatic byte_q_t fill_body(input int n, input logic [7:0] v);
    byte_q_t q;
    repeat (n) q.push_back(v);
    return q;
  endfunction

  task automatic emit_decoded_words();
    result_word_t w;
    int off;
    if (rx_class == CLASS_ACK && (rx_id == ID_ACK_ACK || rx_id == ID_ACK_NAK) &&
        rx_len == ACK_LEN) begin
      w.kind = (rx_id == ID_ACK_NAK) ? KIND_NAK : KIND_ACK;
      w.tag = ACK_LAST_TAG;
      w.value = {16'h0000, rx_payload[1], rx_payload[0]};
      w.last = 1'b1;
      expected_words.push_back(w);
    end else if (rx_class == CLASS_NAV && rx_id == ID_NAV_PVT && rx_len >= PVT_MIN_LEN) begin
      for (int k = 0; k < PVT_WORD_COUNT; k++) begin
        // Byte offsets 4, 8, then 20..28, then 36..68 in steps of four.
        off = (k < 2) ? 4 + 4 * k : ((k < 5) ? 12 + 4 * k : 16 + 4 * k);
        w.kind = KIND_PVT;
        w.tag = 4'(k);
        w.value = {rx_payload[off + 3], rx_payload[off + 2], rx_payload[off + 1],
                   rx_payload[off]};
        w.last = (4'(k) == PVT_LAST_TAG);
        expected_words.push_back(w);
      end
    end
  endtask

  task automatic decode_rx_byte(input logic [7:0] b);
    if (rx_phase inside {PH_CLASS, PH_ID, PH_LENLO, PH_LENHI, PH_PAYLOAD}) begin
      run_a = run_a + b;
      run_b = run_b + run_a;
    end
    case (rx_phase)
      PH_SYNC1: begin
        if (b == SYNC_1) rx_phase = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (b == SYNC_2) begin
          rx_phase = PH_CLASS;
          run_a = 8'h00;
          run_b = 8'h00;
        end else if (b != SYNC_1) begin
          rx_phase = PH_SYNC1;
        end
      end
      PH_CLASS: begin
        rx_class = b;
        rx_phase = PH_ID;
      end
      PH_ID: begin
        rx_id = b;
        rx_phase = PH_LENLO;
      end
      PH_LENLO: begin
        rx_len = {8'h00, b};
        rx_phase = PH_LENHI;
      end
      PH_LENHI: begin
        rx_len[15:8] = b;
        rx_index = 16'h0000;
        rx_phase = (rx_len == 16'h0000) ? PH_CKA : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (rx_index < CAPTURE) rx_payload[rx_index] = b;
        rx_index = rx_index + 16'd1;
        if (rx_index >= rx_len) rx_phase = PH_CKA;
      end
      PH_CKA: begin
        rx_ck_a = b;
        rx_phase = PH_CKB;
      end
      PH_CKB: begin
        if (rx_ck_a == run_a && b == run_b) emit_decoded_words();
        rx_phase = PH_SYNC1;
      end
      default: begin
        rx_phase = PH_SYNC1;
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait(in_steady);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    decode_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input byte_q_t body, input check_fault_t fault);
    logic [7:0]  hdr [4];
    logic [7:0]  ck_a;
    logic [7:0]  ck_b;
    logic [15:0] len;
    len = 16'(body.size());
    hdr = '{cls, id, len[7:0], len[15:8]};
    ck_a = 8'h00;
    ck_b = 8'h00;
    send_byte(SYNC_1);
    send_byte(SYNC_2);
    foreach (hdr[i]) begin
      send_byte(hdr[i]);
      ck_a = ck_a + hdr[i];
      ck_b = ck_b + ck_a;
    end
    foreach (body[i]) begin
      send_byte(body[i]);
      ck_a = ck_a + body[i];
      ck_b = ck_b + ck_a;
    end
    if (fault == CK_BAD_A) ck_a = ck_a ^ (8'h01 << $urandom_range(0, 7));
    if (fault == CK_BAD_B) ck_b = ck_b ^ (8'h01 << $urandom_range(0, 7));
    send_byte(ck_a);
    send_byte(ck_b);
    frames_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic test_sync_hunt();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_2);
    send_byte(SYNC_1);
    send_byte(SYNC_1);
    send_frame(CLASS_ACK, ID_ACK_ACK, '{8'h06, 8'h8A}, CK_GOOD);
    send_byte(SYNC_1);
    send_byte(8'h00);
    send_frame(CLASS_ACK, ID_ACK_NAK, '{8'h06, 8'h24}, CK_GOOD);
  endtask

  task automatic test_acknowledge();
    send_frame(CLASS_ACK, ID_ACK_ACK, '{8'h00, 8'hFF}, CK_GOOD);
    send_frame(CLASS_ACK, ID_ACK_NAK, '{8'hFF, 8'h00}, CK_GOOD);
    send_frame(CLASS_ACK, ID_ACK_ACK, '{8'hFF, 8'hFF}, CK_GOOD);
    send_frame(CLASS_ACK, ID_ACK_NAK, random_body(2), CK_GOOD);
  endtask

  task automatic test_position();
    send_frame(CLASS_NAV, ID_NAV_PVT, random_body(92), CK_GOOD);
    wait_drained();
    send_frame(CLASS_NAV, ID_NAV_PVT, fill_body(92, 8'hFF), CK_GOOD);
  endtask

  task automatic test_zero_length();
    send_frame(8'h0A, 8'h04, fill_body(0, 8'h00), CK_GOOD);
    send_frame(CLASS_ACK, ID_ACK_ACK, fill_body(0, 8'h00), CK_GOOD);
    send_frame(CLASS_ACK, ID_ACK_ACK, random_body(2), CK_GOOD);
  endtask

  task automatic test_ignored_frames();
    send_frame(CLASS_ACK, ID_ACK_ACK, random_body(3), CK_GOOD);
    send_frame(CLASS_ACK, ID_ACK_ACK, random_body(1), CK_GOOD);
    send_frame(CLASS_ACK, 8'h02, random_body(2), CK_GOOD);
    send_frame(CLASS_NAV, ID_NAV_PVT, random_body(91), CK_GOOD);
    send_frame(CLASS_NAV, 8'h06, random_body(92), CK_GOOD);
  endtask

  task automatic test_bad_checksum();
    send_frame(CLASS_ACK, ID_ACK_ACK, random_body(2), CK_BAD_A);
    send_frame(CLASS_ACK, ID_ACK_NAK, random_body(2), CK_BAD_B);
    send_frame(CLASS_ACK, ID_ACK_ACK, random_body(2), CK_GOOD);
  endtask

  task automatic test_random_traffic();
    int start_bytes;
    int pick;
    int n;
    logic [7:0] nb;
    check_fault_t fault;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < 100) begin
      pick = $urandom_range(0, 99);
      fault = CK_GOOD;
      if (pick >= 65 && pick < 80) fault = $urandom_range(0, 1) ? CK_BAD_A : CK_BAD_B;
      if (pick < 35 || (pick >= 65 && pick < 72)) begin
        send_frame(CLASS_ACK, $urandom_range(0, 1) ? ID_ACK_ACK : ID_ACK_NAK,
                   random_body(2), fault);
      end else if (pick < 50 || (pick >= 72 && pick < 76)) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(93, 300) : $urandom_range(92, 100);
        send_frame(CLASS_NAV, ID_NAV_PVT, random_body(n), fault);
      end else if (pick < 80) begin
        send_frame(8'($urandom), 8'($urandom), random_body($urandom_range(0, 12)), fault);
      end else if (pick < 85) begin
        n = $urandom_range(0, 4);
        if (n == 2) n = 3;
        send_frame(CLASS_ACK, $urandom_range(0, 1) ? ID_ACK_ACK : ID_ACK_NAK,
                   random_body(n), CK_GOOD);
      end else if (pick < 90) begin
        send_frame(CLASS_NAV, ID_NAV_PVT, random_body($urandom_range(72, 91)), CK_GOOD);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 8)) begin
          nb = 8'($urandom);
          if (nb == SYNC_2) nb = 8'h63;
          send_byte(nb);
        end
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(SYNC_1);
        nb = 8'($urandom);
        if (nb == SYNC_2) nb = 8'h00;
        send_byte(nb);
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
  endtask

  always @(negedge clk) begin : drive_out_stall
    if (words_checked != stall_mark) begin
      stall_mark = words_checked;
      stall_left = draw_wait(out_steady);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    result_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        $error("unexpected result: kind %0d tag %0d value %h last %0d",
               out_kind, out_tag, out_value, out_last);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind mismatch: expected %0d, actual %0d", want.kind, out_kind);
          fail_count++;
        end
        if (out_tag !== want.tag) begin
          $error("tag mismatch: expected %0d, actual %0d", want.tag, out_tag);
          fail_count++;
        end
        if (out_value !== want.value) begin
          $error("value mismatch: expected %h, actual %h", want.value, out_value);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  initial begin : run_tests
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_sync_hunt();
    test_acknowledge();
    test_position();
    test_zero_length();
    test_ignored_frames();
    test_bad_checksum();
    test_random_traffic();
    wait_drained();
    repeat (40) @(posedge clk);
    $display("Sent %0d bytes in %0d frames plus noise and broken sync sequences.",
             bytes_sent, frames_sent);
    $display("Checked %0d acknowledge and position words.", words_checked);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
